@@ hdl/rgbspec_pkg.sv @@
package rgbspec_pkg;

    localparam int NUM_BINS      = 36;
    localparam int FRAC_BITS_DEF = 15;
    localparam int CH_W          = 16;
    localparam int BIN_W         = 6;
    localparam int VAL_W         = 18;
    localparam int NUM_ROWS      = 7;
    localparam int SEL_COUNT     = 3;
    localparam int QUEUE_DEPTH   = 2;
    localparam int OUT_MAX       = 131071;

    typedef enum logic [2:0] {
        ROW_WHITE   = 3'd0,
        ROW_RED     = 3'd1,
        ROW_GREEN   = 3'd2,
        ROW_BLUE    = 3'd3,
        ROW_YELLOW  = 3'd4,
        ROW_CYAN    = 3'd5,
        ROW_MAGENTA = 3'd6
    } row_t;

    typedef enum logic {
        OP_FULL   = 1'b0,
        OP_SELECT = 1'b1
    } opcode_t;

    // one classified pixel waiting for the bin sequencer
    typedef struct packed {
        opcode_t                         opcode;
        logic [CH_W-1:0]                 wa;
        logic [CH_W-1:0]                 wb;
        logic [CH_W-1:0]                 wc;
        row_t                            rb;
        row_t                            rc;
        logic [SEL_COUNT-1:0][BIN_W-1:0] sel;
    } job_t;

    // basis spectra in units of 1e-5
    localparam int unsigned BASIS_E5 [NUM_ROWS][NUM_BINS] = '{
        '{100000, 99987, 99989, 99984, 99995, 99993, 99986, 99956, 99965, 100000, 100000,
          99995, 99976, 99977, 99937, 99855, 99790, 99830, 99909, 99971, 100000, 100000,
          100000, 100000, 99996, 99989, 99966, 99907, 99866, 99745, 99564, 99490, 99494,
          99491, 99570, 99710},
        '{129, 146, 157, 152, 125, 112, 52, 0, 0, 0, 0, 0,
          0, 0, 0, 0, 0, 0, 5907, 17491, 32966, 50214, 66837, 80927,
          91172, 97286, 100000, 100000, 100000, 100000, 100000, 100000, 100000, 99954,
          99964, 100000},
        '{0, 0, 0, 0, 0, 0, 0, 0, 5065, 16468, 32833, 51896,
          70761, 86859, 97558, 100000, 100000, 100000, 96276, 84612, 67440, 47849, 29140,
          13970, 4045, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{100000, 100000, 100000, 100000, 100000, 100000, 100000, 100000, 96846, 88765,
          76591, 61639, 45727, 30447, 17037, 6916, 1110, 0, 0, 0, 0, 483, 2545, 5289,
          7835, 9743, 11134, 12108, 12651, 12919, 13069, 13073, 12945, 12799, 12704, 12673},
        '{0, 0, 0, 0, 0, 0, 0, 0, 3114, 11068, 23198, 38047,
          53907, 69309, 82802, 92979, 98890, 100000, 100000, 100000, 100000, 99599, 97595,
          94898, 92188, 89955, 88309, 87163, 86469, 86108, 85946, 85968, 86100, 86240,
          86428, 86634},
        '{99583, 99646, 99694, 99670, 99655, 99770, 99953, 100000, 100000, 100000, 100000,
          100000, 100000, 100000, 100000, 100000, 100000, 100000, 93973, 82359, 66910, 49793,
          33149, 19051, 8851, 2665, 0, 0, 0, 0, 0, 0, 4, 87, 26, 0},
        '{100000, 100000, 100000, 100000, 100000, 100000, 100000, 100000, 94902, 83495,
          67115, 48109, 29269, 13144, 2469, 0, 0, 0, 3615, 15336, 32578, 52156, 70911, 86123,
          96000, 100000, 100000, 100000, 100000, 100000, 100000, 100000, 100000, 100000,
          99966, 99914}
    };

    // basis value in Q(frac), rounded to nearest; only called with constant arguments
    function automatic longint unsigned rom_q(input int row, input int bin, input int frac);
        longint unsigned v;
        v = 64'(BASIS_E5[row][bin]);
        return (v * (64'd1 << frac) + 64'd50000) / 64'd100000;
    endfunction

endpackage

@@ hdl/rgbspec_pixel_if.sv @@
interface rgbspec_pixel_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [15:0] red_in;
    logic [15:0] green_in;
    logic [15:0] blue_in;
    logic [5:0]  bin_sel_first;
    logic [5:0]  bin_sel_second;
    logic [5:0]  bin_sel_third;

    modport source (
        output valid, opcode, red_in, green_in, blue_in,
               bin_sel_first, bin_sel_second, bin_sel_third,
        input  ready
    );
    modport sink (
        input  valid, opcode, red_in, green_in, blue_in,
               bin_sel_first, bin_sel_second, bin_sel_third,
        output ready
    );
endinterface

@@ hdl/rgbspec_spec_if.sv @@
interface rgbspec_spec_if;
    logic               valid;
    logic               ready;
    logic signed [17:0] spectral_value;
    logic [5:0]         bin_index;
    logic               last_of_run;

    modport source (
        output valid, spectral_value, bin_index, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, spectral_value, bin_index, last_of_run,
        output ready
    );
endinterface

@@ hdl/rgbspec_front.sv @@
module rgbspec_front
    import rgbspec_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    rgbspec_pixel_if.sink    pixel,
    output job_t             job,
    output logic             job_valid,
    input  logic             job_ready
);

    job_t            job_reg;
    job_t            job_next;
    logic            valid_reg;
    logic            valid_next;
    logic            take;
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
    logic [SEL_COUNT-1:0][BIN_W-1:0] raw_sel;

    assign pixel.ready = !valid_reg || job_ready;
    assign take        = pixel.valid && pixel.ready;
    assign job         = job_reg;
    assign job_valid   = valid_reg;

    assign r = pixel.red_in;
    assign g = pixel.green_in;
    assign b = pixel.blue_in;
    assign raw_sel[0] = pixel.bin_sel_first;
    assign raw_sel[1] = pixel.bin_sel_second;
    assign raw_sel[2] = pixel.bin_sel_third;

    // smallest component weights white, middle gap the secondary, top gap the primary
    always_comb
    begin
        job_next        = job_reg;
        job_next.opcode = opcode_t'(pixel.opcode);
        if (r <= g && r <= b)
        begin
            job_next.wa = r;
            job_next.rb = ROW_CYAN;
            if (g <= b)
            begin
                job_next.wb = g - r;
                job_next.wc = b - g;
                job_next.rc = ROW_BLUE;
            end
            else
            begin
                job_next.wb = b - r;
                job_next.wc = g - b;
                job_next.rc = ROW_GREEN;
            end
        end
        else if (g <= r && g <= b)
        begin
            job_next.wa = g;
            job_next.rb = ROW_MAGENTA;
            if (r <= b)
            begin
                job_next.wb = r - g;
                job_next.wc = b - r;
                job_next.rc = ROW_BLUE;
            end
            else
            begin
                job_next.wb = b - g;
                job_next.wc = r - b;
                job_next.rc = ROW_RED;
            end
        end
        else
        begin
            job_next.wa = b;
            job_next.rb = ROW_YELLOW;
            if (r <= g)
            begin
                job_next.wb = r - b;
                job_next.wc = g - r;
                job_next.rc = ROW_GREEN;
            end
            else
            begin
                job_next.wb = g - b;
                job_next.wc = r - g;
                job_next.rc = ROW_RED;
            end
        end
        for (int i = 0; i < SEL_COUNT; i++)
        begin
            if (raw_sel[i] > BIN_W'(NUM_BINS - 1))
                job_next.sel[i] = BIN_W'(NUM_BINS - 1);
            else
                job_next.sel[i] = raw_sel[i];
        end
    end

    assign valid_next = take || (valid_reg && !job_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            job_reg <= job_next;
    end

endmodule

@@ hdl/rgbspec_queue.sv @@
module rgbspec_queue
    import rgbspec_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  job_t push_job,
    input  logic push_valid,
    output logic push_ready,
    output job_t head_job,
    output logic head_valid,
    input  logic pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_job   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

@@ hdl/rgbspec_back.sv @@
module rgbspec_back
    import rgbspec_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  job_t            job,
    input  logic            job_valid,
    output logic            job_pop,
    rgbspec_spec_if.source  spectrum
);

    localparam int ROM_W  = FRAC_BITS + 1;
    localparam int PROD_W = CH_W + ROM_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int RES_W  = SUM_W - FRAC_BITS;

    logic [ROM_W-1:0]  rom [NUM_ROWS][NUM_BINS];

    logic [BIN_W-1:0]  k_reg;
    logic [BIN_W-1:0]  k_next;
    logic [BIN_W-1:0]  bin;
    logic              last;
    logic              adv;
    logic              issue;

    logic              s1_valid_reg;
    logic [CH_W-1:0]   s1_w_reg [3];
    logic [ROM_W-1:0]  s1_rom_reg [3];
    logic [BIN_W-1:0]  s1_bin_reg;
    logic              s1_last_reg;

    logic              s2_valid_reg;
    logic [PROD_W-1:0] s2_prod_reg [3];
    logic [BIN_W-1:0]  s2_bin_reg;
    logic              s2_last_reg;

    logic              out_valid_reg;
    logic [VAL_W-1:0]  out_value_reg;
    logic [VAL_W-1:0]  out_value_next;
    logic [BIN_W-1:0]  out_bin_reg;
    logic              out_last_reg;

    logic [SUM_W-1:0]  sum;
    logic [RES_W-1:0]  rounded;

    genvar gr, gb;
    generate
        for (gr = 0; gr < NUM_ROWS; gr++)
        begin : g_row
            for (gb = 0; gb < NUM_BINS; gb++)
            begin : g_bin
                assign rom[gr][gb] = ROM_W'(rom_q(gr, gb, FRAC_BITS));
            end
        end
    endgenerate

    // whole pipe holds while the output register is full and not taken
    assign adv   = !out_valid_reg || spectrum.ready;
    assign issue = job_valid;

    always_comb
    begin
        if (job.opcode == OP_SELECT)
        begin
            bin  = job.sel[k_reg[1:0]];
            last = k_reg == BIN_W'(SEL_COUNT - 1);
        end
        else
        begin
            bin  = k_reg;
            last = k_reg == BIN_W'(NUM_BINS - 1);
        end
    end

    assign job_pop = issue && adv && last;

    always_comb
    begin
        k_next = k_reg;
        if (issue && adv)
            k_next = last ? '0 : k_reg + 1'b1;
    end

    // three products summed in Q(F), rounded half up, saturated
    always_comb
    begin
        sum = SUM_W'(s2_prod_reg[0]) + SUM_W'(s2_prod_reg[1]) + SUM_W'(s2_prod_reg[2])
            + (SUM_W'(1) << (FRAC_BITS - 1));
        rounded = sum[SUM_W-1:FRAC_BITS];
        if (rounded > RES_W'(OUT_MAX))
            out_value_next = VAL_W'(OUT_MAX);
        else
            out_value_next = VAL_W'(rounded);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            k_reg <= k_next;
            if (adv)
            begin
                s1_valid_reg  <= issue;
                s2_valid_reg  <= s1_valid_reg;
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_w_reg[0]   <= job.wa;
            s1_w_reg[1]   <= job.wb;
            s1_w_reg[2]   <= job.wc;
            s1_rom_reg[0] <= rom[ROW_WHITE][bin];
            s1_rom_reg[1] <= rom[job.rb][bin];
            s1_rom_reg[2] <= rom[job.rc][bin];
            s1_bin_reg    <= bin;
            s1_last_reg   <= last;

            for (int i = 0; i < 3; i++)
                s2_prod_reg[i] <= PROD_W'(s1_w_reg[i]) * PROD_W'(s1_rom_reg[i]);
            s2_bin_reg    <= s1_bin_reg;
            s2_last_reg   <= s1_last_reg;

            out_value_reg <= out_value_next;
            out_bin_reg   <= s2_bin_reg;
            out_last_reg  <= s2_last_reg;
        end
    end

    assign spectrum.valid          = out_valid_reg;
    assign spectrum.spectral_value = out_value_reg;
    assign spectrum.bin_index      = out_bin_reg;
    assign spectrum.last_of_run    = out_last_reg;

endmodule

@@ hdl/rgb_to_spectrum_conversion_top.sv @@
// each pixel passes the classifier register, queue, s1, s2 and output register
// throughput: one spectral value per cycle from the bin sequencer while the
// output is taken; a full spectrum is 36 values, a selection 3 values per pixel
// a two-entry queue lets the classifier take new pixels while values stream out
// reset: asynchronous active low, clears all valids, queue and bin counter
module rgb_to_spectrum_conversion_top
    import rgbspec_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    rgbspec_pixel_if.sink   pixel,
    rgbspec_spec_if.source  spectrum
);

    job_t front_job;
    logic front_valid;
    logic front_ready;
    job_t head_job;
    logic head_valid;
    logic head_pop;

    rgbspec_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pixel),
        .job       (front_job),
        .job_valid (front_valid),
        .job_ready (front_ready)
    );

    rgbspec_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_job   (front_job),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .head_job   (head_job),
        .head_valid (head_valid),
        .pop        (head_pop)
    );

    rgbspec_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (head_job),
        .job_valid (head_valid),
        .job_pop   (head_pop),
        .spectrum  (spectrum)
    );

`ifndef NO_ASSERTIONS
    // classified pixel must hold while the queue is full
    a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
        front_valid && !front_ready |=> front_valid && $stable(front_job))
        else $error("front job changed while stalled");

    a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        head_pop |-> head_valid && !$isunknown(head_job.opcode))
        else $error("queue popped with no job at head");

    a_bin_range: assert property (@(posedge clk) disable iff (!rst_n)
        spectrum.valid |-> spectrum.bin_index <= 6'(NUM_BINS - 1))
        else $error("bin index out of range");

    a_non_negative: assert property (@(posedge clk) disable iff (!rst_n)
        spectrum.valid |-> !spectrum.spectral_value[17])
        else $error("negative spectral value");
`endif

endmodule
